/* rtl/twc_pkg.sv */
// Shared types, constants and the microcode table of the tile wall collision check.
package twc_pkg;

   localparam int COORD_W   = 16;
   localparam int SIZE_W    = 8;
   localparam int TILE_W    = 6;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int UPC_W     = 4;
   localparam int RECIP_W   = 18;
   localparam int QUO_W     = 16;
   localparam int ADDR_CALC_W = 16;
   localparam int COND_W    = 3;
   localparam int OPND_W    = 2;
   localparam int QLD_W     = 3;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 1'd1;
   localparam logic [CFG_W-1:0]     MAP_SIZE_RESET = 7'd64;

   // microprogram addresses
   localparam logic [UPC_W-1:0] STEP_FETCH  = 4'd0;
   localparam logic [UPC_W-1:0] STEP_DECODE = 4'd1;
   localparam logic [UPC_W-1:0] STEP_WRITE  = 4'd2;
   localparam logic [UPC_W-1:0] STEP_MXL    = 4'd3;
   localparam logic [UPC_W-1:0] STEP_MXH    = 4'd4;
   localparam logic [UPC_W-1:0] STEP_MYL    = 4'd5;
   localparam logic [UPC_W-1:0] STEP_MYH    = 4'd6;
   localparam logic [UPC_W-1:0] STEP_MDONE  = 4'd7;
   localparam logic [UPC_W-1:0] STEP_CHECK  = 4'd8;
   localparam logic [UPC_W-1:0] STEP_SCAN   = 4'd9;
   localparam logic [UPC_W-1:0] STEP_EMIT   = 4'd10;

   // jump conditions
   localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
   localparam logic [COND_W-1:0] COND_NO_REQ   = 3'd2;
   localparam logic [COND_W-1:0] COND_QUERY    = 3'd3;
   localparam logic [COND_W-1:0] COND_EMPTY    = 3'd4;
   localparam logic [COND_W-1:0] COND_MORE     = 3'd5;
   localparam logic [COND_W-1:0] COND_OUT_BUSY = 3'd6;

   // multiplier operand select
   localparam logic [OPND_W-1:0] OPND_XLO = 2'd0;
   localparam logic [OPND_W-1:0] OPND_XHI = 2'd1;
   localparam logic [OPND_W-1:0] OPND_YLO = 2'd2;
   localparam logic [OPND_W-1:0] OPND_YHI = 2'd3;

   // quotient register load select
   localparam logic [QLD_W-1:0] QLD_NONE   = 3'd0;
   localparam logic [QLD_W-1:0] QLD_COL_LO = 3'd1;
   localparam logic [QLD_W-1:0] QLD_COL_HI = 3'd2;
   localparam logic [QLD_W-1:0] QLD_ROW_LO = 3'd3;
   localparam logic [QLD_W-1:0] QLD_ROW_HI = 3'd4;

   typedef struct packed {
      logic [COND_W-1:0] cond;
      logic [UPC_W-1:0]  target;
      logic              done;
      logic              fetch;
      logic              mem_wr;
      logic [OPND_W-1:0] opnd_sel;
      logic [QLD_W-1:0]  q_load;
      logic              scan_init;
      logic              scan_rd;
      logic              emit;
   } ctrl_word_type;

   typedef struct packed {
      logic no_req;
      logic is_query;
      logic empty;
      logic more;
      logic out_busy;
   } status_type;

   function automatic ctrl_word_type ucode(input logic [UPC_W-1:0] upc);
      ctrl_word_type w;
      w = '0;
      w.cond   = COND_NEVER;
      w.target = STEP_FETCH;
      w.q_load = QLD_NONE;
      w.opnd_sel = OPND_XLO;
      case (upc)
         STEP_FETCH: begin
            w.fetch  = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = STEP_FETCH;
         end
         STEP_DECODE: begin
            w.cond   = COND_QUERY;
            w.target = STEP_MXL;
         end
         STEP_WRITE: begin
            w.mem_wr = 1'b1;
            w.done   = 1'b1;
         end
         STEP_MXL: begin
            w.opnd_sel = OPND_XLO;
         end
         STEP_MXH: begin
            w.opnd_sel = OPND_XHI;
            w.q_load   = QLD_COL_LO;
         end
         STEP_MYL: begin
            w.opnd_sel = OPND_YLO;
            w.q_load   = QLD_COL_HI;
         end
         STEP_MYH: begin
            w.opnd_sel = OPND_YHI;
            w.q_load   = QLD_ROW_LO;
         end
         STEP_MDONE: begin
            w.q_load = QLD_ROW_HI;
         end
         STEP_CHECK: begin
            w.scan_init = 1'b1;
            w.cond      = COND_EMPTY;
            w.target    = STEP_EMIT;
         end
         STEP_SCAN: begin
            w.scan_rd = 1'b1;
            w.cond    = COND_MORE;
            w.target  = STEP_SCAN;
         end
         STEP_EMIT: begin
            w.emit   = 1'b1;
            w.cond   = COND_OUT_BUSY;
            w.target = STEP_EMIT;
            w.done   = 1'b1;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

/* rtl/twc_sequencer.sv */
// Microprogram sequencer: step counter, control table lookup and conditional jumps.
module twc_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  twc_pkg::status_type    status,
   output twc_pkg::ctrl_word_type ctrl
);
   import twc_pkg::*;

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   logic             taken;

   assign ctrl = ucode(upc_ff);

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:    taken = 1'b0;
         COND_ALWAYS:   taken = 1'b1;
         COND_NO_REQ:   taken = status.no_req;
         COND_QUERY:    taken = status.is_query;
         COND_EMPTY:    taken = status.empty;
         COND_MORE:     taken = status.more;
         COND_OUT_BUSY: taken = status.out_busy;
         default:       taken = 1'b0;
      endcase
   end

   always_comb begin
      if (taken) begin
         upc_in = ctrl.target;
      end else if (ctrl.done) begin
         upc_in = STEP_FETCH;
      end else begin
         upc_in = upc_ff + UPC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_FETCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

/* rtl/twc_datapath.sv */
// Datapath: request latch, reciprocal multiplier, tile bounds, scan counters, wall memory.
module twc_datapath #(
   parameter int TILE_SIZE = 32,
   parameter int MAP_MAX   = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  twc_pkg::ctrl_word_type        ctrl,
   output twc_pkg::status_type           status,
   input  logic [twc_pkg::CFG_W-1:0]     eff_w,
   input  logic [twc_pkg::CFG_W-1:0]     eff_h,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [twc_pkg::TILE_W-1:0]    req_tile_col,
   input  logic [twc_pkg::TILE_W-1:0]    req_tile_row,
   input  logic                          req_wall_bit,
   input  logic [twc_pkg::COORD_W-1:0]   req_box_x,
   input  logic [twc_pkg::COORD_W-1:0]   req_box_y,
   input  logic [twc_pkg::SIZE_W-1:0]    req_box_w,
   input  logic [twc_pkg::SIZE_W-1:0]    req_box_h,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit
);
   import twc_pkg::*;

   localparam int L      = $clog2(TILE_SIZE);
   localparam int SH     = COORD_W + L;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << SH) + TILE_SIZE - 1) / TILE_SIZE);
   localparam int PW     = COORD_W + RECIP_W;
   localparam int TW     = (MAP_MAX > 1) ? $clog2(MAP_MAX) : 1;
   localparam int DEPTH  = MAP_MAX * MAP_MAX;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [ADDR_CALC_W-1:0] MAP_MAX_A = ADDR_CALC_W'(MAP_MAX);
   localparam logic [8:0] MAP_MAX_9 = 9'(MAP_MAX);

   // request latch
   logic                 type_ff;
   logic [TILE_W-1:0]    tcol_ff;
   logic [TILE_W-1:0]    trow_ff;
   logic                 wbit_ff;
   logic [COORD_W-1:0]   bx_ff;
   logic [COORD_W-1:0]   by_ff;
   logic [SIZE_W-1:0]    bw_ff;
   logic [SIZE_W-1:0]    bh_ff;
   logic                 accept;

   // multiplier and quotients
   logic [COORD_W+1:0]   x_end;
   logic [COORD_W+1:0]   y_end;
   logic [COORD_W-1:0]   x_lo;
   logic [COORD_W-1:0]   y_lo;
   logic [COORD_W-1:0]   opnd;
   logic [PW-1:0]        prod_ff;
   logic [PW-1:0]        prod_in;
   logic [QUO_W-1:0]     quo;
   logic [QUO_W-1:0]     col_lo_q_ff;
   logic [QUO_W-1:0]     col_hi_q_ff;
   logic [QUO_W-1:0]     row_lo_q_ff;
   logic [QUO_W-1:0]     row_hi_q_ff;

   // bounds
   logic [QUO_W-1:0]     col_max;
   logic [QUO_W-1:0]     row_max;
   logic [QUO_W-1:0]     col_end;
   logic [QUO_W-1:0]     row_end;
   logic                 empty;

   // scan
   logic [TW-1:0]        col_ff;
   logic [TW-1:0]        col_in;
   logic [TW-1:0]        row_ff;
   logic [TW-1:0]        row_in;
   logic [TW-1:0]        col_start_ff;
   logic [TW-1:0]        col_stop_ff;
   logic [TW-1:0]        row_stop_ff;
   logic                 col_last;
   logic                 row_last;

   // memory
   logic                 wall_mem [DEPTH];
   logic                 clearing_ff;
   logic                 clearing_in;
   logic [AW-1:0]        clr_addr_ff;
   logic [AW-1:0]        clr_addr_in;
   logic [ADDR_CALC_W-1:0] wr_addr_full;
   logic [ADDR_CALC_W-1:0] rd_addr_full;
   logic                 wr_ok;
   logic                 rd_data_ff;
   logic                 rd_pend_ff;
   logic                 rd_pend_in;
   logic                 acc_ff;
   logic                 acc_in;

   // response
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_hit_ff;
   logic                 rsp_hit_in;
   logic                 out_busy;
   logic                 rsp_load;

   // ---------------- request intake ----------------
   assign req_stall = ~(ctrl.fetch & ~clearing_ff);
   assign accept    = ctrl.fetch & ~clearing_ff & req_valid;

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         tcol_ff <= req_tile_col;
         trow_ff <= req_tile_row;
         wbit_ff <= req_wall_bit;
         bx_ff   <= req_box_x;
         by_ff   <= req_box_y;
         bw_ff   <= req_box_w;
         bh_ff   <= req_box_h;
      end
   end

   // ---------------- tile index by reciprocal multiply ----------------
   // last covered pixel; sign bit set means the box lies left of / above the map
   assign x_end = {{2{bx_ff[COORD_W-1]}}, bx_ff} + (COORD_W+2)'(bw_ff) - (COORD_W+2)'(1);
   assign y_end = {{2{by_ff[COORD_W-1]}}, by_ff} + (COORD_W+2)'(bh_ff) - (COORD_W+2)'(1);
   assign x_lo  = bx_ff[COORD_W-1] ? '0 : bx_ff;
   assign y_lo  = by_ff[COORD_W-1] ? '0 : by_ff;

   always_comb begin
      case (ctrl.opnd_sel)
         OPND_XLO: opnd = x_lo;
         OPND_XHI: opnd = x_end[COORD_W-1:0];
         OPND_YLO: opnd = y_lo;
         OPND_YHI: opnd = y_end[COORD_W-1:0];
         default:  opnd = x_lo;
      endcase
   end

   assign prod_in = PW'(opnd) * PW'(RECIP);
   assign quo     = QUO_W'(prod_ff >> SH);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (ctrl.q_load)
         QLD_COL_LO: col_lo_q_ff <= quo;
         QLD_COL_HI: col_hi_q_ff <= quo;
         QLD_ROW_LO: row_lo_q_ff <= quo;
         QLD_ROW_HI: row_hi_q_ff <= quo;
         default: begin
         end
      endcase
   end

   // ---------------- clamp to map and detect empty range ----------------
   assign col_max = QUO_W'(eff_w) - QUO_W'(1);
   assign row_max = QUO_W'(eff_h) - QUO_W'(1);
   assign col_end = (col_hi_q_ff < col_max) ? col_hi_q_ff : col_max;
   assign row_end = (row_hi_q_ff < row_max) ? row_hi_q_ff : row_max;

   assign empty = (bw_ff == '0) | (bh_ff == '0) | x_end[COORD_W+1] | y_end[COORD_W+1] |
                  (eff_w == '0) | (eff_h == '0) |
                  (col_lo_q_ff > col_end) | (row_lo_q_ff > row_end);

   // ---------------- row-major scan ----------------
   assign col_last = (col_ff == col_stop_ff);
   assign row_last = (row_ff == row_stop_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (ctrl.scan_init) begin
         col_in = col_lo_q_ff[TW-1:0];
         row_in = row_lo_q_ff[TW-1:0];
      end else if (ctrl.scan_rd) begin
         if (col_last) begin
            col_in = col_start_ff;
            row_in = row_ff + TW'(1);
         end else begin
            col_in = col_ff + TW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      row_ff <= row_in;
      if (ctrl.scan_init) begin
         col_start_ff <= col_lo_q_ff[TW-1:0];
         col_stop_ff  <= col_end[TW-1:0];
         row_stop_ff  <= row_end[TW-1:0];
      end
   end

   // ---------------- wall memory with clearing pass ----------------
   assign wr_ok = (9'(trow_ff) < MAP_MAX_9) & (9'(tcol_ff) < MAP_MAX_9);
   assign wr_addr_full = ADDR_CALC_W'(trow_ff) * MAP_MAX_A + ADDR_CALC_W'(tcol_ff);
   assign rd_addr_full = ADDR_CALC_W'(row_ff) * MAP_MAX_A + ADDR_CALC_W'(col_ff);

   assign clearing_in = clearing_ff & (clr_addr_ff != LAST_ADDR);
   assign clr_addr_in = clearing_ff ? clr_addr_ff + AW'(1) : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         wall_mem[clr_addr_ff] <= 1'b0;
      end else if (ctrl.mem_wr & wr_ok) begin
         wall_mem[wr_addr_full[AW-1:0]] <= wbit_ff;
      end
      if (ctrl.scan_rd) begin
         rd_data_ff <= wall_mem[rd_addr_full[AW-1:0]];
      end
   end

   // fold each read into the hit flag in the cycle after it is issued
   assign rd_pend_in = ctrl.scan_rd;
   assign acc_in     = ctrl.scan_init ? 1'b0 : (acc_ff | (rd_pend_ff & rd_data_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= rd_pend_in;
      end
      acc_ff <= acc_in;
   end

   // ---------------- response register ----------------
   assign out_busy = rsp_valid_ff & rsp_stall;
   assign rsp_load = ctrl.emit & ~out_busy;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = acc_in;
      end else if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   // ---------------- status to sequencer ----------------
   assign status.no_req   = ~accept;
   assign status.is_query = (type_ff == REQ_QUERY);
   assign status.empty    = empty;
   assign status.more     = ~(col_last & row_last);
   assign status.out_busy = out_busy;

endmodule

/* rtl/tile_wall_collision_check_core.sv */
// Top level of the tile wall collision check: map size registers, sequencer and datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type, req_tile_*, req_wall_bit, req_box_*
//   rsp      out        rsp_valid/rsp_stall  rsp_hit
//   csr      in         csr_write_en         csr_index, csr_wdata
//
// A wall write runs fetch, decode and write; a query runs fetch, decode, the multiply
// steps, check, one wall-bit read per cycle over the clamped range unless it is empty, and emit.
// After reset a clearing pass zeroes the MAP_MAX * MAP_MAX wall bits, one bit a cycle,
// during which no request is taken; map size writes are taken as ever.
// A result waits in the output register under rsp_stall while the next request is fetched;
// the next result waits until that register is free.
module tile_wall_collision_check_core #(
   parameter int TILE_SIZE = 32,
   parameter int MAP_MAX   = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [twc_pkg::TILE_W-1:0]         req_tile_col,
   input  logic [twc_pkg::TILE_W-1:0]         req_tile_row,
   input  logic                               req_wall_bit,
   input  logic signed [twc_pkg::COORD_W-1:0] req_box_x,
   input  logic signed [twc_pkg::COORD_W-1:0] req_box_y,
   input  logic [twc_pkg::SIZE_W-1:0]         req_box_w,
   input  logic [twc_pkg::SIZE_W-1:0]         req_box_h,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   input  logic                               csr_write_en,
   input  logic [twc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [twc_pkg::CFG_W-1:0]          csr_wdata
);
   import twc_pkg::*;

   localparam logic [8:0] MAP_MAX_9 = 9'(MAP_MAX);

   logic [CFG_W-1:0] map_width_ff;
   logic [CFG_W-1:0] map_width_in;
   logic [CFG_W-1:0] map_height_ff;
   logic [CFG_W-1:0] map_height_in;
   logic [CFG_W-1:0] eff_w;
   logic [CFG_W-1:0] eff_h;
   ctrl_word_type    ctrl;
   status_type       status;

   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MAP_WIDTH:  map_width_in  = csr_wdata;
            CSR_MAP_HEIGHT: map_height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= MAP_SIZE_RESET;
         map_height_ff <= MAP_SIZE_RESET;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   // sizes beyond the storage fall back to the storage size
   assign eff_w = (9'(map_width_ff) > MAP_MAX_9) ? CFG_W'(MAP_MAX) : map_width_ff;
   assign eff_h = (9'(map_height_ff) > MAP_MAX_9) ? CFG_W'(MAP_MAX) : map_height_ff;

   twc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   twc_datapath #(
      .TILE_SIZE (TILE_SIZE),
      .MAP_MAX   (MAP_MAX)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .status       (status),
      .eff_w        (eff_w),
      .eff_h        (eff_h),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_tile_col (req_tile_col),
      .req_tile_row (req_tile_row),
      .req_wall_bit (req_wall_bit),
      .req_box_x    (req_box_x),
      .req_box_y    (req_box_y),
      .req_box_w    (req_box_w),
      .req_box_h    (req_box_h),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_hit      (rsp_hit)
   );

endmodule
